/* sv/ldfs_pkg.sv */
`default_nettype none

package ldfs_pkg;

  // Default number of digit pattern bytes per frame
  localparam int unsigned DigitCountDefault = 4;

  // Register reset values
  localparam logic [7:0] DataCmdReset    = 8'd64;
  localparam logic [7:0] StartAddrReset  = 8'd192;
  localparam logic [7:0] DisplayCmdReset = 8'd139;

  // Digit code used for digits past the fourth
  localparam logic [3:0] BlankCode = 4'hF;

  // Transaction numbers within a frame
  localparam logic [1:0] TxnData     = 2'd0;
  localparam logic [1:0] TxnPatterns = 2'd1;
  localparam logic [1:0] TxnDisplay  = 2'd2;

  // Waveform segment lengths, stored as length minus one
  localparam logic [2:0] StartUnits   = 3'd1;
  localparam logic [2:0] BitUnits     = 3'd2;
  localparam logic [2:0] AckLowUnits  = 3'd4;
  localparam logic [2:0] AckHighUnits = 3'd1;
  localparam logic [2:0] StopUnits    = 3'd1;
  localparam logic [2:0] LastBit      = 3'd7;

  typedef enum logic [1:0] {
    CfgDataCmd    = 2'd0,
    CfgStartAddr  = 2'd1,
    CfgDisplayCmd = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PhIdle    = 4'd0,
    PhStart   = 4'd1,
    PhBitLow  = 4'd2,
    PhBitHigh = 4'd3,
    PhAckLow  = 4'd4,
    PhAckHigh = 4'd5,
    PhStopA   = 4'd6,
    PhStopB   = 4'd7,
    PhStopC   = 4'd8
  } phase_e;

  typedef struct packed {
    logic       action;
    logic [3:0] digit0;
    logic [3:0] digit1;
    logic [3:0] digit2;
    logic [3:0] digit3;
    logic       dots_on;
  } in_word_t;

  typedef struct packed {
    logic clock_pin;
    logic data_pin;
    logic busy_res;
    logic frame_done;
    logic rejected;
  } out_word_t;

  typedef struct packed {
    logic [7:0] data_cmd;
    logic [7:0] start_address;
    logic [7:0] disp_cmd;
  } cfg_t;

  // Seven-segment pattern of a digit code, dot segment in bit 7
  function automatic logic [7:0] seg_pattern(logic [3:0] code, logic dots);
    logic [7:0] p;
    case (code)
      4'd0:    p = 8'h3F;
      4'd1:    p = 8'h06;
      4'd2:    p = 8'h5B;
      4'd3:    p = 8'h4F;
      4'd4:    p = 8'h66;
      4'd5:    p = 8'h6D;
      4'd6:    p = 8'h7D;
      4'd7:    p = 8'h07;
      4'd8:    p = 8'h7F;
      4'd9:    p = 8'h6F;
      4'd10:   p = 8'h40;
      4'd11:   p = 8'h80;
      default: p = 8'h00;
    endcase
    return p | {dots, 7'b0};
  endfunction

endpackage

`default_nettype wire

/* sv/ldfs_cfg_regs.sv */
`default_nettype none

module ldfs_cfg_regs (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [7:0]   cfg_data_i,
  output ldfs_pkg::cfg_t    cfg_o
);
  import ldfs_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Register write decode; unused index is dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgDataCmd:    cfg_d.data_cmd      = cfg_data_i;
        CfgStartAddr:  cfg_d.start_address = cfg_data_i;
        CfgDisplayCmd: cfg_d.disp_cmd      = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.data_cmd      <= DataCmdReset;
      cfg_q.start_address <= StartAddrReset;
      cfg_q.disp_cmd      <= DisplayCmdReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* sv/ldfs_seq.sv */
`default_nettype none

module ldfs_seq #(
  parameter int unsigned DigitCount = ldfs_pkg::DigitCountDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          fire_i,
  input  ldfs_pkg::in_word_t in_word_i,
  input  ldfs_pkg::cfg_t     cfg_i,
  output ldfs_pkg::out_word_t res_o,
  output logic               busy_o
);
  import ldfs_pkg::*;

  localparam int unsigned ByteW   = $clog2(DigitCount + 1);
  localparam int unsigned SegIdxW = (DigitCount > 1) ? $clog2(DigitCount) : 1;
  localparam logic [ByteW-1:0] LastPattern = ByteW'(DigitCount);

  phase_e            phase_q, phase_d;
  logic [2:0]        unit_q, unit_d;
  logic [2:0]        bit_q, bit_d;
  logic [ByteW-1:0]  byte_q, byte_d;
  logic [7:0]        shift_q, shift_d;
  logic [1:0]        txn_q, txn_d;
  logic              clk_q, clk_d;
  logic              dat_q, dat_d;
  logic [7:0]        seg_q [DigitCount];
  logic [3:0]        code  [DigitCount];
  logic [3:0]        digits [4];

  logic req, tick, load, reject, step, done;
  logic [7:0] first_byte, seg_byte;

  assign req    = fire_i & in_word_i.action;
  assign tick   = fire_i & ~in_word_i.action;
  assign load   = req & (phase_q == PhIdle);
  assign reject = req & (phase_q != PhIdle);
  // Segment boundary reached on this tick
  assign step   = tick & (phase_q != PhIdle) & (unit_q == 3'd0);
  assign done   = step & (phase_q == PhStopC) & (txn_q == TxnDisplay);

  // Digit codes; digits past the fourth are blank
  always_comb begin
    digits[0] = in_word_i.digit0;
    digits[1] = in_word_i.digit1;
    digits[2] = in_word_i.digit2;
    digits[3] = in_word_i.digit3;
    for (int i = 0; i < DigitCount; i++) begin
      code[i] = (i < 4) ? digits[2'(i)] : BlankCode;
    end
  end

  // Byte sources: register byte at a transaction start, pattern after an ack
  always_comb begin
    case (txn_q)
      TxnData:    first_byte = cfg_i.data_cmd;
      TxnDisplay: first_byte = cfg_i.disp_cmd;
      default:    first_byte = cfg_i.start_address;
    endcase
  end
  assign seg_byte = seg_q[byte_q[SegIdxW-1:0]];

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (load) begin
      phase_d = PhStart;
    end else if (step) begin
      case (phase_q)
        PhStart:   phase_d = PhBitLow;
        PhBitLow:  phase_d = PhBitHigh;
        PhBitHigh: phase_d = (bit_q != LastBit) ? PhBitLow : PhAckLow;
        PhAckLow:  phase_d = PhAckHigh;
        PhAckHigh: phase_d = (txn_q == TxnPatterns && byte_q < LastPattern) ?
                             PhBitLow : PhStopA;
        PhStopA:   phase_d = PhStopB;
        PhStopB:   phase_d = PhStopC;
        PhStopC:   phase_d = (txn_q != TxnDisplay) ? PhStart : PhIdle;
        default:   phase_d = PhIdle;
      endcase
    end
  end

  // Counters, shift byte and pin levels
  always_comb begin
    unit_d  = unit_q;
    bit_d   = bit_q;
    byte_d  = byte_q;
    shift_d = shift_q;
    txn_d   = txn_q;
    clk_d   = clk_q;
    dat_d   = dat_q;
    if (load) begin
      txn_d  = TxnData;
      byte_d = '0;
      bit_d  = 3'd0;
      clk_d  = 1'b1;
      dat_d  = 1'b1;
      unit_d = StartUnits;
    end else if (tick && phase_q != PhIdle && unit_q != 3'd0) begin
      unit_d = unit_q - 3'd1;
    end else if (step) begin
      case (phase_q)
        PhStart: begin
          byte_d  = '0;
          shift_d = first_byte;
          bit_d   = 3'd0;
          clk_d   = 1'b0;
          dat_d   = first_byte[0];
          unit_d  = BitUnits;
        end
        PhBitLow: begin
          clk_d  = 1'b1;
          unit_d = BitUnits;
        end
        PhBitHigh: begin
          clk_d = 1'b0;
          if (bit_q != LastBit) begin
            bit_d   = bit_q + 3'd1;
            shift_d = shift_q >> 1;
            dat_d   = shift_q[1];
            unit_d  = BitUnits;
          end else begin
            unit_d = AckLowUnits;
          end
        end
        PhAckLow: begin
          clk_d  = 1'b1;
          unit_d = AckHighUnits;
        end
        PhAckHigh: begin
          clk_d = 1'b0;
          if (txn_q == TxnPatterns && byte_q < LastPattern) begin
            byte_d  = byte_q + 1'b1;
            shift_d = seg_byte;
            bit_d   = 3'd0;
            dat_d   = seg_byte[0];
            unit_d  = BitUnits;
          end else begin
            unit_d = StopUnits;
          end
        end
        PhStopA: begin
          clk_d  = 1'b0;
          dat_d  = 1'b0;
          unit_d = StopUnits;
        end
        PhStopB: begin
          clk_d  = 1'b1;
          dat_d  = 1'b0;
          unit_d = StopUnits;
        end
        PhStopC: begin
          clk_d = 1'b1;
          dat_d = 1'b1;
          if (txn_q != TxnDisplay) begin
            txn_d  = txn_q + 2'd1;
            byte_d = '0;
            unit_d = StartUnits;
          end else begin
            unit_d = 3'd0;
          end
        end
        default: begin
          clk_d  = 1'b1;
          dat_d  = 1'b1;
          unit_d = 3'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      unit_q  <= 3'd0;
      bit_q   <= 3'd0;
      byte_q  <= '0;
      shift_q <= 8'd0;
      txn_q   <= TxnData;
      clk_q   <= 1'b1;
      dat_q   <= 1'b1;
    end else if (fire_i) begin
      phase_q <= phase_d;
      unit_q  <= unit_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      shift_q <= shift_d;
      txn_q   <= txn_d;
      clk_q   <= clk_d;
      dat_q   <= dat_d;
    end
  end

  // Pattern store, filled by a request accepted while idle
  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < DigitCount; i++) begin
        seg_q[i] <= seg_pattern(code[i], in_word_i.dots_on);
      end
    end
  end

  // Result word: a tick reports the levels held during its unit,
  // a request reports the levels the next tick will drive
  assign res_o.clock_pin  = load ? 1'b1 : clk_q;
  assign res_o.data_pin   = load ? 1'b1 : dat_q;
  assign res_o.busy_res   = (phase_d != PhIdle);
  assign res_o.frame_done = done;
  assign res_o.rejected   = reject;
  assign busy_o           = (phase_q != PhIdle);

endmodule

`default_nettype wire

/* sv/ldfs_out_stage.sv */
`default_nettype none

module ldfs_out_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  output logic                fire_o,
  input  ldfs_pkg::out_word_t res_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output ldfs_pkg::out_word_t out_data_o
);
  import ldfs_pkg::*;

  logic      valid_q, valid_d;
  out_word_t data_q;

  // Take a word whenever the result register is empty or draining
  assign in_stall_o = valid_q & out_stall_i;
  assign fire_o     = in_valid_i & ~in_stall_o;
  assign valid_d    = fire_o | (valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_o) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

/* sv/led_display_frame_serializer_unit.sv */
// Each accepted word's result is registered and shown in the next cycle.
// Throughput: one word per cycle unless a held result stalls the input; the
// sequencer state and the result register both advance on every accepted word.
// Reset (rst_ni low, asynchronous): sequencer idle, pins high, registers
// back to 64 / 192 / 139, result register empty. Pattern store not cleared.
`default_nettype none

module led_display_frame_serializer_unit #(
  parameter int unsigned DigitCount = ldfs_pkg::DigitCountDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  ldfs_pkg::in_word_t   in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output ldfs_pkg::out_word_t  out_data_o,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_idx_i,
  input  wire logic [7:0]      cfg_data_i
);
  import ldfs_pkg::*;

  cfg_t      cfg;
  out_word_t res;
  logic      fire;
  logic      busy;

  ldfs_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ldfs_seq #(
    .DigitCount (DigitCount)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .in_word_i (in_data_i),
    .cfg_i     (cfg),
    .res_o     (res),
    .busy_o    (busy)
  );

  ldfs_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .fire_o      (fire),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Input side only stalls behind a held result word
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty result register");

  // A rejected request only happens mid-frame
  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_data_i.action && !busy |=> !out_data_o.rejected && out_data_o.busy_res)
    else $error("idle request not started");

  // Frame end leaves the sequencer idle with both pins high
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res.frame_done |=> !busy && !out_data_o.busy_res)
    else $error("frame end did not return to idle");

  // An accepted word always loads the result register
  a_fire_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("accepted word produced no result");

endmodule

`default_nettype wire
